>>> src/mi4_pkg.sv
// Package for the 4x4 matrix inverse core: defaults, sequencer codes and term decode.
`default_nettype none

package mi4_pkg;

  localparam int MI4_WORD_BITS = 32;
  localparam int MI4_FRAC_BITS = 16;

  // Sequencer phases of the multiply-accumulate schedule
  typedef enum logic [2:0] {
    PH_MIN = 3'b001,   // 2x2 minors of row pairs 0/1 and 2/3
    PH_ADJ = 3'b010,   // adjugate entries from minors
    PH_DET = 3'b100    // determinant from adjugate column 0
  } phase_t;

  // Source of the wide multiplicand
  typedef enum logic [1:0] {
    SRC_MAT = 2'd0,
    SRC_MIN = 2'd1,
    SRC_ADJ = 2'd2
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [3:0] mc_addr;   // multiplicand index in its store
    logic [3:0] mp_addr;   // multiplier index in the matrix store
    logic       sub;       // subtract the product
    logic       last;      // last term of the accumulation group
  } term_t;

  // Column pair (a < b) to minor slot within one row pair
  function automatic logic [2:0] col_pair(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] cp;
    case ({a, b})
      4'b0001: cp = 3'd0;
      4'b0010: cp = 3'd1;
      4'b0011: cp = 3'd2;
      4'b0110: cp = 3'd3;
      4'b0111: cp = 3'd4;
      4'b1011: cp = 3'd5;
      default: cp = 3'd0;
    endcase
    return cp;
  endfunction

  // Decode one product term of the schedule
  function automatic term_t term_info(input phase_t ph, input logic [3:0] g,
                                      input logic [1:0] t);
    term_t      ti;
    logic       rp;
    logic [2:0] cp;
    logic [1:0] a, b, j, i, p, c0, c1, c2, ct, pa, pb;
    ti = '0;
    a  = 2'd0;
    b  = 2'd0;
    c0 = 2'd0;
    c1 = 2'd0;
    c2 = 2'd0;
    case (ph)
      PH_MIN: begin
        rp = (g >= 4'd6);
        cp = rp ? 3'(g - 4'd6) : g[2:0];
        case (cp)
          3'd0: begin a = 2'd0; b = 2'd1; end
          3'd1: begin a = 2'd0; b = 2'd2; end
          3'd2: begin a = 2'd0; b = 2'd3; end
          3'd3: begin a = 2'd1; b = 2'd2; end
          3'd4: begin a = 2'd1; b = 2'd3; end
          default: begin a = 2'd2; b = 2'd3; end
        endcase
        ti.src = SRC_MAT;
        if (t == 2'd0) begin
          ti.mc_addr = {rp, 1'b0, a};
          ti.mp_addr = {rp, 1'b1, b};
          ti.sub     = 1'b0;
        end else begin
          ti.mc_addr = {rp, 1'b0, b};
          ti.mp_addr = {rp, 1'b1, a};
          ti.sub     = 1'b1;
        end
        ti.last = (t == 2'd1);
      end
      PH_ADJ: begin
        // adj[r][c] is the signed cofactor with row c and column r removed
        j = g[3:2];
        i = g[1:0];
        case (j)
          2'd0: begin c0 = 2'd1; c1 = 2'd2; c2 = 2'd3; end
          2'd1: begin c0 = 2'd0; c1 = 2'd2; c2 = 2'd3; end
          2'd2: begin c0 = 2'd0; c1 = 2'd1; c2 = 2'd3; end
          default: begin c0 = 2'd0; c1 = 2'd1; c2 = 2'd2; end
        endcase
        case (t)
          2'd0: begin ct = c0; pa = c1; pb = c2; end
          2'd1: begin ct = c1; pa = c0; pb = c2; end
          default: begin ct = c2; pa = c0; pb = c1; end
        endcase
        rp = ~i[1];
        p  = i ^ 2'd1;
        cp = col_pair(pa, pb);
        ti.src     = SRC_MIN;
        ti.mc_addr = rp ? (4'(cp) + 4'd6) : {1'b0, cp};
        ti.mp_addr = {p, ct};
        ti.sub     = (t == 2'd1) ^ g[2] ^ g[0];
        ti.last    = (t == 2'd2);
      end
      PH_DET: begin
        ti.src     = SRC_ADJ;
        ti.mc_addr = {t, 2'b00};
        ti.mp_addr = {2'b00, t};
        ti.sub     = 1'b0;
        ti.last    = (t == 2'd3);
      end
      default: ti = '0;
    endcase
    return ti;
  endfunction

endpackage

`default_nettype wire

>>> src/matrix_inverse_4x4_core.sv
// 4x4 fixed-point matrix inverse by adjugate, one shared serial multiply-accumulate unit.
// Schedule: after the 16th element the multiply-accumulate unit forms the minors, adjugate
//   and determinant, then the restoring divider produces the inverse elements one by one.
// Flow: the next matrix is taken only after all 16 inverse elements have been handed on;
//   in_tready is low while the multiply-accumulate unit, the divider or the output is busy.
// Reset: rst_n synchronous active low clears the load counter, sequencer and output valid;
//   the matrix, minor and adjugate stores hold no reset value.
`default_nettype none

module matrix_inverse_4x4_core
  import mi4_pkg::*;
#(
  parameter int WORD_BITS = MI4_WORD_BITS,
  parameter int FRAC_BITS = MI4_FRAC_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [((WORD_BITS+7)/8)*8-1:0]       in_tdata,   // [W-1:0] element_value
  input  wire                                  in_tuser,   // [0] first_element
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0]       out_tdata,  // [W-1:0] inverse_value
  output logic                                 out_tuser,  // [0] singular
  output logic                                 out_tlast   // last_element
);

  localparam int W      = WORD_BITS;
  localparam int TD_W   = ((WORD_BITS + 7) / 8) * 8;
  localparam int MIN_W  = 2 * W + 1;   // 2x2 minor
  localparam int ADJ_W  = 3 * W + 2;   // adjugate entry
  localparam int DET_W  = 4 * W + 2;   // determinant
  localparam int ACC_W  = 4 * W + 4;   // accumulator and shifted multiplicand
  localparam int DV_W   = 5 * W + 4;   // divider numerator / shifted divisor
  localparam int CNT_W  = $clog2(W + 1);

  // Sequencer states
  typedef enum logic [9:0] {
    S_LOAD  = 10'b00_0000_0001,  // taking elements
    S_TLD_A = 10'b00_0000_0010,  // fetch multiplicand
    S_TLD_B = 10'b00_0000_0100,  // fetch multiplier
    S_MUL   = 10'b00_0000_1000,  // one multiplier bit per cycle
    S_WB    = 10'b00_0001_0000,  // store accumulated group
    S_DLOAD = 10'b00_0010_0000,  // fetch adjugate entry, take magnitude
    S_DPRE  = 10'b00_0100_0000,  // build rounded numerator and divisor
    S_DCHK  = 10'b00_1000_0000,  // quotient range check
    S_DSTEP = 10'b01_0000_0000,  // one quotient bit per cycle
    S_DOUT  = 10'b10_0000_0000   // saturate and hand to output register
  } state_t;

  state_t             state_r, state_nxt;

  logic [W-1:0]       mat_r [16];
  logic [MIN_W-1:0]   min_r [12];
  logic [ADJ_W-1:0]   adj_r [16];
  logic [3:0]         load_cnt_r;

  phase_t             phase_r;
  logic [3:0]         g_r;
  logic [1:0]         t_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   mc_r;
  logic [W-1:0]       mp_r;
  logic [CNT_W-1:0]   bit_r;

  logic [DET_W-1:0]   absd_r;
  logic               dneg_r;
  logic               dzero_r;
  logic [ADJ_W-1:0]   absa_r;
  logic               aneg_r;
  logic [DV_W-1:0]    num_r;
  logic [DV_W-1:0]    dsh_r;
  logic [W:0]         q_r;
  logic               ovf_r;
  logic [3:0]         k_r;

  logic               out_valid_r;
  logic [W-1:0]       out_data_r;
  logic               out_sing_r;
  logic               out_last_r;

  term_t              ti;
  logic [3:0]         mat_addr;
  logic [W-1:0]       mat_rdata;
  logic [3:0]         adj_addr;
  logic [ADJ_W-1:0]   adj_rdata;
  logic [ACC_W-1:0]   mc_ext;
  logic               mul_msb;
  logic               mul_neg;
  logic [ACC_W-1:0]   addend;
  logic [ACC_W-1:0]   acc_sum;
  logic               acc_neg;
  logic [DV_W:0]      div_diff;
  logic               div_ge;
  logic               res_neg;
  logic [W:0]         res_limit;
  logic [W:0]         res_mag;
  logic [W-1:0]       res_val;
  logic               out_free;
  logic               in_take;
  logic [3:0]         slot;

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TD_W'(out_data_r);
  assign out_tuser  = out_sing_r;
  assign out_tlast  = out_last_r;

  assign out_free = !out_valid_r || out_tready;
  assign in_take  = in_tvalid && in_tready;
  assign slot     = in_tuser ? 4'd0 : load_cnt_r;

  // Term decode and store reads
  always_comb begin
    ti        = term_info(phase_r, g_r, t_r);
    mat_addr  = (state_r == S_TLD_A) ? ti.mc_addr : ti.mp_addr;
    mat_rdata = mat_r[mat_addr];
    adj_addr  = (state_r == S_DLOAD) ? k_r : ti.mc_addr;
    adj_rdata = adj_r[adj_addr];
    case (ti.src)
      SRC_MAT: mc_ext = {{(ACC_W - W){mat_rdata[W-1]}}, mat_rdata};
      SRC_MIN: mc_ext = {{(ACC_W - MIN_W){min_r[ti.mc_addr][MIN_W-1]}},
                         min_r[ti.mc_addr]};
      SRC_ADJ: mc_ext = {{(ACC_W - ADJ_W){adj_rdata[ADJ_W-1]}}, adj_rdata};
      default: mc_ext = '0;
    endcase
  end

  // Shared serial multiply-accumulate: two's complement multiplier, MSB weight negative
  always_comb begin
    mul_msb = (bit_r == CNT_W'(W - 1));
    mul_neg = ti.sub ^ mul_msb;
    addend  = mp_r[0] ? (mul_neg ? ~mc_r : mc_r) : '0;
    acc_sum = acc_r + addend + ACC_W'(mp_r[0] & mul_neg);
    acc_neg = acc_r[ACC_W-1];
  end

  // Restoring divider step
  always_comb begin
    div_diff = {1'b0, num_r} - {1'b0, dsh_r};
    div_ge   = !div_diff[DV_W];
  end

  // Rounded quotient saturation and sign
  always_comb begin
    res_neg   = aneg_r ^ dneg_r;
    res_limit = (W + 1)'(1) << (W - 1);
    if (!res_neg) begin
      res_limit = res_limit - (W + 1)'(1);
    end
    res_mag = (ovf_r || (q_r > res_limit)) ? res_limit : q_r;
    res_val = res_neg ? W'(-res_mag) : res_mag[W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_take && (slot == 4'd15)) begin
          state_nxt = S_TLD_A;
        end
      end
      S_TLD_A: state_nxt = S_TLD_B;
      S_TLD_B: state_nxt = S_MUL;
      S_MUL: begin
        if (mul_msb) begin
          state_nxt = ti.last ? S_WB : S_TLD_A;
        end
      end
      S_WB:    state_nxt = (phase_r == PH_DET) ? S_DLOAD : S_TLD_A;
      S_DLOAD: state_nxt = dzero_r ? S_DOUT : S_DPRE;
      S_DPRE:  state_nxt = S_DCHK;
      S_DCHK:  state_nxt = S_DSTEP;
      S_DSTEP: begin
        if (bit_r == CNT_W'(W)) begin
          state_nxt = S_DOUT;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          state_nxt = (k_r == 4'd15) ? S_LOAD : S_DLOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // output register: loaded from S_DOUT, emptied by the sink
      if ((state_r == S_DOUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_take) begin
            mat_r[slot] <= in_tdata[W-1:0];
            load_cnt_r  <= slot + 4'd1;
            phase_r     <= PH_MIN;
            g_r         <= 4'd0;
            t_r         <= 2'd0;
          end
        end
        S_TLD_A: begin
          mc_r <= mc_ext;
          if (t_r == 2'd0) begin
            acc_r <= '0;
          end
        end
        S_TLD_B: begin
          mp_r  <= mat_rdata;
          bit_r <= '0;
        end
        S_MUL: begin
          acc_r <= acc_sum;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
          bit_r <= bit_r + CNT_W'(1);
          if (mul_msb && !ti.last) begin
            t_r <= t_r + 2'd1;
          end
        end
        S_WB: begin
          t_r <= 2'd0;
          case (phase_r)
            PH_MIN: begin
              min_r[g_r] <= acc_r[MIN_W-1:0];
              if (g_r == 4'd11) begin
                phase_r <= PH_ADJ;
                g_r     <= 4'd0;
              end else begin
                g_r <= g_r + 4'd1;
              end
            end
            PH_ADJ: begin
              adj_r[g_r] <= acc_r[ADJ_W-1:0];
              if (g_r == 4'd15) begin
                phase_r <= PH_DET;
                g_r     <= 4'd0;
              end else begin
                g_r <= g_r + 4'd1;
              end
            end
            PH_DET: begin
              absd_r  <= acc_neg ? DET_W'(-acc_r) : acc_r[DET_W-1:0];
              dneg_r  <= acc_neg;
              dzero_r <= (acc_r == '0);
              k_r     <= 4'd0;
            end
            default: g_r <= 4'd0;
          endcase
        end
        S_DLOAD: begin
          aneg_r <= adj_rdata[ADJ_W-1];
          absa_r <= adj_rdata[ADJ_W-1] ? ADJ_W'(-adj_rdata) : adj_rdata;
        end
        S_DPRE: begin
          // (|A| * 2^(2F) * 2 + |D|) / (2 |D|) rounds half away from zero
          num_r <= (DV_W'(absa_r) << (2 * FRAC_BITS + 1)) + DV_W'(absd_r);
          dsh_r <= DV_W'(absd_r) << (W + 2);
        end
        S_DCHK: begin
          ovf_r <= div_ge;
          dsh_r <= dsh_r >> 1;
          q_r   <= '0;
          bit_r <= '0;
        end
        S_DSTEP: begin
          if (div_ge) begin
            num_r <= div_diff[DV_W-1:0];
          end
          q_r   <= {q_r[W-1:0], div_ge};
          dsh_r <= dsh_r >> 1;
          bit_r <= bit_r + CNT_W'(1);
        end
        S_DOUT: begin
          if (out_free) begin
            out_data_r  <= dzero_r ? '0 : res_val;
            out_sing_r  <= dzero_r;
            out_last_r  <= (k_r == 4'd15);
            k_r         <= k_r + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_matrix_inverse_4x4_core.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse core.
`timescale 1ns / 100ps
`default_nettype none

module tb_matrix_inverse_4x4_core
  import mi4_pkg::*;
;

  localparam int W  = MI4_WORD_BITS;
  localparam int F  = MI4_FRAC_BITS;
  localparam int DW = ((W + 7) / 8) * 8;
  localparam logic [W-1:0] ONE = W'(1) << F;

  typedef logic signed [255:0] wide_t;

  // one element transaction for the load port
  typedef struct {
    logic [W-1:0] elem;
    logic         first;
    logic         drain;   // hold off until every expected result is back
  } elem_item_t;

  // one inverse element the core should produce
  typedef struct {
    logic [W-1:0] value;
    logic         singular;
    logic         last;
  } inv_elem_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic          in_tuser = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [DW-1:0] out_tdata;
  logic          out_tuser;
  logic          out_tlast;

  matrix_inverse_4x4_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  elem_item_t   load_q[$];
  inv_elem_t    inv_expect_q[$];
  elem_item_t   cur_item;
  logic [W-1:0] shadow_mat[16];
  int unsigned  shadow_slot = 0;
  int unsigned  errors = 0;
  int unsigned  n_loaded = 0, n_inverses = 0, n_singular = 0, n_checked = 0;
  logic         stim_done = 1'b0;
  wide_t        mw[16];

  // 3x3 determinant of the matrix with one row and one column removed
  function automatic wide_t minor_det(input int sr, input int sc);
    int    rr[3], cc[3];
    int    nr, nc;
    wide_t e[3][3];
    nr = 0;
    nc = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != sr) begin rr[nr] = i; nr++; end
      if (i != sc) begin cc[nc] = i; nc++; end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) e[i][j] = mw[rr[i]*4 + cc[j]];
    return e[0][0]*(e[1][1]*e[2][2] - e[1][2]*e[2][1])
         - e[0][1]*(e[1][0]*e[2][2] - e[1][2]*e[2][0])
         + e[0][2]*(e[1][0]*e[2][1] - e[1][1]*e[2][0]);
  endfunction

  // load one element; on the last slot push the 16 inverse elements
  task automatic load_element(input elem_item_t it);
    int unsigned slot;
    wide_t       adj[16];
    wide_t       det, num, den, quo, lim;
    logic        neg;
    inv_elem_t   r;
    slot = it.first ? 0 : shadow_slot;
    shadow_mat[slot] = it.elem;
    shadow_slot = (slot + 1) % 16;
    n_loaded++;
    if (slot != 15) return;
    for (int i = 0; i < 16; i++) mw[i] = wide_t'($signed(shadow_mat[i]));
    for (int rw = 0; rw < 4; rw++)
      for (int cl = 0; cl < 4; cl++) begin
        adj[rw*4+cl] = minor_det(cl, rw);
        if ((rw + cl) % 2 == 1) adj[rw*4+cl] = -adj[rw*4+cl];
      end
    det = '0;
    for (int cl = 0; cl < 4; cl++) det = det + adj[cl*4] * mw[cl];
    n_inverses++;
    if (det == 0) n_singular++;
    for (int k = 0; k < 16; k++) begin
      r.last = (k == 15);
      if (det == 0) begin
        r.value    = '0;
        r.singular = 1'b1;
      end else begin
        // round half away from zero: (2|A|*2^2F + |D|) / 2|D|
        neg = (adj[k] < 0) != (det < 0);
        num = ((adj[k] < 0 ? -adj[k] : adj[k]) <<< (2*F + 1)) + (det < 0 ? -det : det);
        den = (det < 0 ? -det : det) <<< 1;
        quo = num / den;
        lim = (wide_t'(1) <<< (W - 1)) - (neg ? 0 : 1);
        if (quo > lim) quo = lim;
        r.value    = neg ? W'(-quo) : W'(quo);
        r.singular = 1'b0;
      end
      inv_expect_q.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_elem(input logic [W-1:0] v, input logic f, input logic d = 1'b0);
    elem_item_t it;
    it.elem  = v;
    it.first = f;
    it.drain = d;
    load_q.push_back(it);
  endtask

  function automatic logic [W-1:0] rand_elem(input int mode);
    case (mode)
      0: return W'($signed($urandom_range(0, 1 << (F + 3))) - (1 << (F + 2)));  // +-4.0
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return {1'b0, {(W-1){1'b1}}};
          1: return {1'b1, {(W-1){1'b0}}};
          2: return '0;
          3: return W'(1);
          4: return ONE;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic push_matrix(input int mode, input logic sing, input logic d = 1'b0);
    logic [W-1:0] m[16];
    for (int i = 0; i < 16; i++) m[i] = rand_elem(mode);
    if (sing) for (int c = 0; c < 4; c++) m[12 + c] = m[c];  // repeated row
    for (int i = 0; i < 16; i++) push_elem(m[i], i == 0, d && i == 0);
  endtask

  initial begin
    // directed: aborted load restarted by first_element
    push_elem(ONE, 1'b0);
    push_elem($urandom, 1'b0);
    // diag(eps, -eps, eps, eps): inverse saturates to both ends of the range
    for (int i = 0; i < 16; i++)
      push_elem((i % 5 != 0) ? '0 : (i == 5 ? {W{1'b1}} : W'(1)), i == 0);
    // diag(max, min, max, min): huge determinant, tiny inverse
    for (int i = 0; i < 16; i++)
      push_elem((i % 5 != 0) ? '0 :
                ((i % 10 == 0) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}}), i == 0);
    // all-zero matrix is singular
    for (int i = 0; i < 16; i++) push_elem('0, i == 0);
    // random: mostly whole matrices, some noise and aborted loads
    // the drain window is as wide as the largest step, so it is always hit
    while (load_q.size() < 330) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6)) push_elem($urandom, 1'($urandom_range(0, 1)));
      push_matrix($urandom_range(0, 2), $urandom_range(0, 5) == 0,
                  load_q.size() >= 150 && load_q.size() < 172);
    end
    stim_done = 1'b1;
  end

  // ------------------------------------------------------------- load driver
  int unsigned burst_left = 0, gap_left = 0;
  logic        accepted = 1'b0;

  always @(posedge clk) begin
    accepted <= 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      load_element(cur_item);
      accepted <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || accepted)) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (load_q.size() > 0 &&
                   !(load_q[0].drain && inv_expect_q.size() > 0)) begin
        cur_item  = load_q.pop_front();
        in_tdata  <= DW'(cur_item.elem);
        in_tuser  <= cur_item.first;
        in_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------- result monitor
  int unsigned ready_cyc = 0;
  int unsigned long_hold = 0;
  logic        held_once = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      ready_cyc <= ready_cyc + 1;
      if (!held_once && n_checked >= 40) begin
        // long back-pressure: the core fills up and stalls its load side
        held_once  <= 1'b1;
        long_hold  <= 6000;
        out_tready <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold  <= long_hold - 1;
        out_tready <= (long_hold == 1);
      end else if ((ready_cyc / 800) % 3 == 0) begin
        out_tready <= 1'b1;
      end else if ((ready_cyc / 800) % 3 == 1) begin
        out_tready <= (ready_cyc % 7) != 3;
      end else begin
        out_tready <= $urandom_range(0, 2) != 0;
      end
    end
  end

  always @(posedge clk) begin
    inv_elem_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (inv_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result data=%h singular=%b last=%b",
                 $time, out_tdata[W-1:0], out_tuser, out_tlast);
      end else begin
        e = inv_expect_q.pop_front();
        n_checked++;
        if (out_tdata[W-1:0] !== e.value) begin
          errors++;
          $display("%0t: inverse_value expected %h actual %h", $time, e.value,
                   out_tdata[W-1:0]);
        end
        if (out_tuser !== e.singular) begin
          errors++;
          $display("%0t: singular expected %b actual %b", $time, e.singular, out_tuser);
        end
        if (out_tlast !== e.last) begin
          errors++;
          $display("%0t: last_element expected %b actual %b", $time, e.last, out_tlast);
        end
      end
    end
  end

  // ------------------------------------------------------------ run control
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (stim_done && load_q.size() == 0);
    while (in_tvalid || inv_expect_q.size() > 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    if (inv_expect_q.size() > 0) errors++;
    $display("Loaded %0d elements, %0d inverses (%0d singular), %0d results checked",
             n_loaded, n_inverses, n_singular, n_checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", inv_expect_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/mi4_pkg.sv
src/matrix_inverse_4x4_core.sv
sim/tb_matrix_inverse_4x4_core.sv
